@@ sv/ordered_list_store_top_defines.svh @@
// assertion macros for the ordered list store checker
// expects clk and arst_n in the scope where a macro is used
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// condition now implies consequence in the same cycle
`define OLS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list store: check failed in same cycle");

// condition now implies consequence in the next cycle
`define OLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list store: check failed one cycle later");

`endif

@@ sv/ols_pkg.sv @@
// shared constants, codes and types of the ordered list store
// no dependencies
package ols_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int FUNC_W = 3;
	localparam int POS_W  = 6;
	localparam int SYM_W  = 8;
	localparam int STAT_W = 3;
	localparam int FPOS_W = 5;
	localparam int LEN_W  = 5;
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;
	localparam logic [FUNC_W-1:0] FN_SHOW   = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [FPOS_W-1:0] fpos;
		logic [SYM_W-1:0]  entry;
		logic [LEN_W-1:0]  length;
		logic              last;
	} res_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [SYM_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

@@ sv/ols_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ols_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/ols_ctrl.sv @@
// sequencer of the ordered list store: decode, read-modify-write walks, output register
// depends on ols_pkg; drives the entry ram through a ram_req_t
module ols_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [ols_pkg::FUNC_W-1:0]   func,
	input  logic [ols_pkg::POS_W-1:0]    position,
	input  logic [ols_pkg::SYM_W-1:0]    symbol,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output ols_pkg::res_t                rsp,
	output ols_pkg::ram_req_t            ram_req,
	input  logic [ols_pkg::SYM_W-1:0]    ram_rdata
);
	import ols_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_DEL  = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_SHOW = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic [POS_W-1:0] pos_q;
	logic [SYM_W-1:0] sym_q;
	res_t             res_q;
	res_t             out_q;
	logic             out_valid_q;
	logic             show_q;
	logic             move_s1;
	logic             look_s1;
	logic [IDX_W-1:0] wa_s1;

	logic             accept;
	logic             full;
	logic             out_free;
	logic             ins_more;
	logic             del_more;
	logic             srch_more;
	logic             hit;
	logic [CMP_W-1:0] in_pos_x;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] k_x;

	function automatic res_t mk_res(input logic [STAT_W-1:0] st, input logic [CNT_W-1:0] fp,
			input logic [SYM_W-1:0] ent, input logic [CNT_W-1:0] len, input logic lst);
		res_t r;
		r.status = st;
		r.fpos   = FPOS_W'(fp);
		r.entry  = ent;
		r.length = LEN_W'(len);
		r.last   = lst;
		return r;
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign in_pos_x  = CMP_W'(position);
	assign pos_x     = CMP_W'(pos_q);
	assign cnt_x     = CMP_W'(count_q);
	assign k_x       = CMP_W'(k_q);
	assign full      = (count_q >= CNT_W'(CAPACITY));
	assign ins_more  = (k_x >= pos_x);
	assign del_more  = ((k_x + CMP_W'(1)) < cnt_x);
	assign srch_more = (k_q < count_q);
	assign hit       = look_s1 && (ram_rdata == sym_q);

	// write port: pending move first, then append or the closing insert write
	always_comb begin
		ram_req = '0;
		if (move_s1) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = wa_s1;
			ram_req.wdata = ram_rdata;
		end else if (accept && (func == FN_APPEND) && !full) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = IDX_W'(count_q);
			ram_req.wdata = symbol;
		end else if ((state_q == S_INS) && !ins_more) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = IDX_W'(pos_q - POS_W'(1));
			ram_req.wdata = sym_q;
		end
		case (state_q)
			S_INS: begin
				ram_req.re    = ins_more;
				ram_req.raddr = IDX_W'(k_q - CNT_W'(1));
			end
			S_DEL: begin
				ram_req.re    = del_more;
				ram_req.raddr = IDX_W'(k_q + CNT_W'(1));
			end
			S_SRCH: begin
				ram_req.re    = srch_more;
				ram_req.raddr = IDX_W'(k_q);
			end
			S_SHOW: begin
				ram_req.re    = !look_s1;
				ram_req.raddr = IDX_W'(k_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			show_q      <= 1'b0;
			move_s1     <= 1'b0;
			look_s1     <= 1'b0;
		end else begin
			move_s1 <= ((state_q == S_INS) && ins_more) || ((state_q == S_DEL) && del_more);
			look_s1 <= ((state_q == S_SRCH) && srch_more) || ((state_q == S_SHOW) && !look_s1);
			wa_s1   <= IDX_W'(k_q);
			if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q  <= position;
						sym_q  <= symbol;
						show_q <= 1'b0;
						k_q    <= '0;
						state_q <= S_EMIT;
						case (func)
							FN_CLEAR: begin
								count_q <= '0;
								res_q   <= mk_res(STAT_OK, '0, '0, '0, 1'b1);
							end
							FN_APPEND: begin
								if (full) begin
									res_q <= mk_res(STAT_FULL, '0, '0, count_q, 1'b1);
								end else begin
									count_q <= count_q + CNT_W'(1);
									res_q   <= mk_res(STAT_OK, '0, '0, count_q + CNT_W'(1), 1'b1);
								end
							end
							FN_INSERT: begin
								if ((position == '0) || (in_pos_x > (cnt_x + CMP_W'(1)))) begin
									res_q <= mk_res(STAT_BADPOS, '0, '0, count_q, 1'b1);
								end else if (full) begin
									res_q <= mk_res(STAT_FULL, '0, '0, count_q, 1'b1);
								end else begin
									k_q     <= count_q;
									state_q <= S_INS;
								end
							end
							FN_DELETE: begin
								if ((position == '0) || (in_pos_x > cnt_x)) begin
									res_q <= mk_res(STAT_BADPOS, '0, '0, count_q, 1'b1);
								end else begin
									k_q     <= CNT_W'(position - POS_W'(1));
									state_q <= S_DEL;
								end
							end
							FN_SEARCH: begin
								state_q <= S_SRCH;
							end
							FN_SHOW: begin
								if (count_q == '0) begin
									res_q <= mk_res(STAT_EMPTY, '0, '0, '0, 1'b1);
								end else begin
									state_q <= S_SHOW;
								end
							end
							default: begin
								res_q <= mk_res(STAT_OK, '0, '0, count_q, 1'b1);
							end
						endcase
					end
				end
				S_INS: begin
					if (ins_more) begin
						k_q <= k_q - CNT_W'(1);
					end else if (!move_s1) begin
						count_q <= count_q + CNT_W'(1);
						res_q   <= mk_res(STAT_OK, '0, '0, count_q + CNT_W'(1), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_DEL: begin
					if (del_more) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!move_s1) begin
						count_q <= count_q - CNT_W'(1);
						res_q   <= mk_res(STAT_OK, '0, '0, count_q - CNT_W'(1), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_SRCH: begin
					if (hit) begin
						res_q   <= mk_res(STAT_OK, k_q, '0, count_q, 1'b1);
						state_q <= S_EMIT;
					end else if (srch_more) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!look_s1) begin
						res_q   <= mk_res(STAT_NOTFOUND, '0, '0, count_q, 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_SHOW: begin
					if (look_s1) begin
						res_q   <= mk_res(STAT_OK, k_q + CNT_W'(1), ram_rdata, count_q,
							(k_q + CNT_W'(1)) == count_q);
						show_q  <= ((k_q + CNT_W'(1)) != count_q);
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= show_q ? S_SHOW : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/ordered_list_store_top.sv @@
// ordered list store: byte list with clear, append, insert, delete, search and show
// depends on ols_pkg, ols_ctrl and ols_ram
//
// request channel req_valid/req_ready carries func, position and symbol; one request is
// worked at a time and req_ready is high only while the sequencer is idle.
// response channel rsp_valid/rsp_ready carries status, found_position, entry, length and
// last; a one-entry output register sits on it, so the next request is taken while a
// finished response still waits for its transfer.
// path from request transfer to response valid:
//   clear, append, errors, unused codes: the result is registered, then moved to the output register
//   insert, delete: a shift walk over the entries from the position on, then the output register
//   search: reads the entries in order until a hit or the end of the list
//   show: one response per entry, last set on the final one
// the entries live in a 16 x 8 ram with one write and one registered read port; each
// shift step reads one entry and writes it back in the next cycle, so one entry per cycle.
// reset clears the length and the sequencer; ram contents are not cleared, only slots
// below the length are ever read.
// a stalled receiver holds the response and stalls the sequencer once the next response
// is ready, which in turn holds req_ready low.
module ordered_list_store_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [ols_pkg::FUNC_W-1:0]    func,
	input  logic [ols_pkg::POS_W-1:0]     position,
	input  logic [ols_pkg::SYM_W-1:0]     symbol,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [ols_pkg::STAT_W-1:0]    status,
	output logic [ols_pkg::FPOS_W-1:0]    found_position,
	output logic [ols_pkg::SYM_W-1:0]     entry,
	output logic [ols_pkg::LEN_W-1:0]     length,
	output logic                          last
);
	import ols_pkg::*;

	res_t             rsp;
	ram_req_t         ram_req;
	logic [SYM_W-1:0] ram_rdata;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.position  (position),
		.symbol    (symbol),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	ols_ram #(
		.WIDTH (SYM_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign status         = rsp.status;
	assign found_position = rsp.fpos;
	assign entry          = rsp.entry;
	assign length         = rsp.length;
	assign last           = rsp.last;

endmodule

@@ sv/ols_checker.sv @@
// port-level checks of the ordered list store, bound to the top level
// depends on ols_pkg and ordered_list_store_top_defines.svh
`include "ordered_list_store_top_defines.svh"

module ols_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [ols_pkg::FUNC_W-1:0]    func,
	input logic [ols_pkg::POS_W-1:0]     position,
	input logic [ols_pkg::SYM_W-1:0]     symbol,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [ols_pkg::STAT_W-1:0]    status,
	input logic [ols_pkg::FPOS_W-1:0]    found_position,
	input logic [ols_pkg::SYM_W-1:0]     entry,
	input logic [ols_pkg::LEN_W-1:0]     length,
	input logic                          last
);
	import ols_pkg::*;

	res_t rsp_bits;

	assign rsp_bits = {status, found_position, entry, length, last};

	// a waiting request keeps its payload
	`OLS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable({func, position, symbol}))

	// a stalled response keeps its payload
	`OLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits))

	// length never exceeds the capacity
	`OLS_ASSERT_NOW(a_len_cap, rsp_valid, length <= LEN_W'(CAPACITY))

	// a reported position lies inside the list
	`OLS_ASSERT_NOW(a_pos_in_list, rsp_valid && (found_position != '0), (status == STAT_OK) && (found_position <= length))

	// an error response is always the last one of its request
	`OLS_ASSERT_NOW(a_err_last, rsp_valid && (status != STAT_OK), last && (entry == '0) && (found_position == '0))

endmodule

bind ordered_list_store_top ols_checker u_ols_checker (.*);
